// ----- rtl/core/thbs_pkg.sv -----
package thbs_pkg;

    // Configuration register indexes on the write port.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REARM    = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MUTE     = 2'd3;

    localparam int TICKS_WIDTH = 16;
    localparam int MUTE_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH = TICKS_WIDTH;

    localparam logic [TICKS_WIDTH-1:0] DEBOUNCE_RESET = 16'd15;
    localparam logic [TICKS_WIDTH-1:0] HOLD_RESET     = 16'd1000;
    localparam logic [TICKS_WIDTH-1:0] REARM_RESET    = 16'd200;
    localparam logic [MUTE_WIDTH-1:0]  MUTE_RESET     = 8'd10;

    typedef struct packed {
        logic switch_level;
        logic detect_level;
        logic remote_level;
    } in_beat_t;

    typedef struct packed {
        logic engaged;
        logic mute;
    } out_beat_t;

    typedef struct packed {
        logic [TICKS_WIDTH-1:0] debounce_ticks;
        logic [TICKS_WIDTH-1:0] hold_ticks;
        logic [TICKS_WIDTH-1:0] rearm_ticks;
        logic [MUTE_WIDTH-1:0]  mute_ticks;
    } cfg_t;

    // Single-bit control state of the switch logic.
    typedef struct packed {
        logic engaged;
        logic armed;
        logic last_switch;
        logic fall_recorded;
        logic rise_recorded;
    } flags_t;

endpackage

// ----- rtl/core/tap_hold_bypass_switch.sv -----
// Channel   Direction  Signals                       Beat
// in        input      in_valid, in_ready, in_data   one millisecond tick of pin levels
// out       output     out_valid, out_ready, out_data  engaged and mute for that tick
// cfg       input      cfg_we, cfg_index, cfg_data   one register write, no wait
//
// Each tick passes the state registers, one pass of the decision logic and
// the result register, so a new beat is taken every cycle while the output is not stalled.
// The result register decouples the two sides; a beat is taken whenever the
// result register is empty or its beat leaves in the same cycle.
// Reset (rst_n low, asynchronous) restores the default thresholds, clears the
// engaged, armed and edge state and marks the footswitch released.
// A stall on the output holds the result and blocks input only while full.
module tap_hold_bypass_switch
    import thbs_pkg::*;
#(
    parameter int AGE_WIDTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_beat_t                   in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_beat_t                  out_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t cfg;

    // Switch state, advanced once per accepted tick.
    flags_t                flags_reg;
    flags_t                flags_next;
    logic [AGE_WIDTH-1:0]  fall_age_reg;
    logic [AGE_WIDTH-1:0]  fall_age_next;
    logic [AGE_WIDTH-1:0]  rise_age_reg;
    logic [AGE_WIDTH-1:0]  rise_age_next;
    logic [MUTE_WIDTH-1:0] mute_left_reg;
    logic [MUTE_WIDTH-1:0] mute_left_next;

    // Result register.
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t out_data_next;

    logic in_take;

    thbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thbs_step #(
        .AGE_WIDTH (AGE_WIDTH)
    ) u_step (
        .cfg            (cfg),
        .beat           (in_data),
        .flags          (flags_reg),
        .fall_age       (fall_age_reg),
        .rise_age       (rise_age_reg),
        .mute_left      (mute_left_reg),
        .flags_next     (flags_next),
        .fall_age_next  (fall_age_next),
        .rise_age_next  (rise_age_next),
        .mute_left_next (mute_left_next),
        .result         (out_data_next)
    );

    // The result register can take a new beat when it is empty or draining now.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.engaged       <= 1'b0;
            flags_reg.armed         <= 1'b0;
            flags_reg.last_switch   <= 1'b1;
            flags_reg.fall_recorded <= 1'b0;
            flags_reg.rise_recorded <= 1'b0;
            fall_age_reg            <= '0;
            rise_age_reg            <= '0;
            mute_left_reg           <= '0;
            out_valid_reg           <= 1'b0;
        end
        else if (in_take)
        begin
            flags_reg     <= flags_next;
            fall_age_reg  <= fall_age_next;
            rise_age_reg  <= rise_age_next;
            mute_left_reg <= mute_left_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The payload needs no reset; it is only looked at while valid.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/thbs_cfg.sv -----
module thbs_cfg
    import thbs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.hold_ticks     <= HOLD_RESET;
            cfg_reg.rearm_ticks    <= REARM_RESET;
            cfg_reg.mute_ticks     <= MUTE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data;
                REG_HOLD:     cfg_reg.hold_ticks     <= cfg_data;
                REG_REARM:    cfg_reg.rearm_ticks    <= cfg_data;
                REG_MUTE:     cfg_reg.mute_ticks     <= cfg_data[MUTE_WIDTH-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/thbs_step.sv -----
module thbs_step
    import thbs_pkg::*;
#(
    parameter int AGE_WIDTH = 16
)
(
    input  cfg_t                  cfg,
    input  in_beat_t              beat,
    input  flags_t                flags,
    input  logic [AGE_WIDTH-1:0]  fall_age,
    input  logic [AGE_WIDTH-1:0]  rise_age,
    input  logic [MUTE_WIDTH-1:0] mute_left,
    output flags_t                flags_next,
    output logic [AGE_WIDTH-1:0]  fall_age_next,
    output logic [AGE_WIDTH-1:0]  rise_age_next,
    output logic [MUTE_WIDTH-1:0] mute_left_next,
    output out_beat_t             result
);

    localparam int CMP_WIDTH = (AGE_WIDTH > TICKS_WIDTH) ? AGE_WIDTH : TICKS_WIDTH;

    function automatic logic [AGE_WIDTH-1:0] sat_inc(input logic [AGE_WIDTH-1:0] age);
        sat_inc = (&age) ? age : age + 1'b1;
    endfunction

    // An edge that was never seen, or whose age has saturated, is older than any limit.
    function automatic logic expired(input logic rec, input logic [AGE_WIDTH-1:0] age,
                                     input logic [TICKS_WIDTH-1:0] thr);
        logic [CMP_WIDTH-1:0] age_w;
        logic [CMP_WIDTH-1:0] thr_w;
        age_w = CMP_WIDTH'(age);
        thr_w = CMP_WIDTH'(thr);
        expired = !rec || (&age) || (age_w > thr_w);
    endfunction

    always_comb
    begin
        logic rise_ok;
        flags_next     = flags;
        fall_age_next  = flags.fall_recorded ? sat_inc(fall_age) : fall_age;
        rise_age_next  = flags.rise_recorded ? sat_inc(rise_age) : rise_age;
        mute_left_next = mute_left;
        rise_ok        = 1'b0;

        if (flags.last_switch && !beat.switch_level && !flags.fall_recorded)
        begin
            flags_next.fall_recorded = 1'b1;
            fall_age_next            = '0;
        end
        if (!flags.last_switch && beat.switch_level && flags.armed && !flags.rise_recorded)
        begin
            flags_next.rise_recorded = 1'b1;
            rise_age_next            = '0;
        end
        flags_next.last_switch = beat.switch_level;

        if (mute_left != '0)
        begin
            mute_left_next = mute_left - 1'b1;
        end
        else if (!beat.detect_level)
        begin
            if (flags.engaged == beat.remote_level)
            begin
                flags_next.engaged = !beat.remote_level;
                mute_left_next     = cfg.mute_ticks;
            end
        end
        else if (flags.armed)
        begin
            if (beat.switch_level)
            begin
                rise_ok = expired(flags_next.rise_recorded, rise_age_next, cfg.debounce_ticks);
                if (flags.engaged && rise_ok &&
                    expired(flags_next.fall_recorded, fall_age_next, cfg.hold_ticks))
                begin
                    flags_next.engaged       = 1'b0;
                    mute_left_next           = cfg.mute_ticks;
                    flags_next.armed         = 1'b0;
                    flags_next.fall_recorded = 1'b0;
                    flags_next.rise_recorded = 1'b0;
                    fall_age_next            = '0;
                    rise_age_next            = '0;
                end
                else if (rise_ok &&
                         expired(flags_next.fall_recorded, fall_age_next, cfg.rearm_ticks))
                begin
                    flags_next.armed         = 1'b0;
                    flags_next.fall_recorded = 1'b0;
                    flags_next.rise_recorded = 1'b0;
                    fall_age_next            = '0;
                    rise_age_next            = '0;
                end
            end
        end
        else if (!beat.switch_level &&
                 expired(flags_next.fall_recorded, fall_age_next, cfg.debounce_ticks))
        begin
            flags_next.engaged = !flags.engaged;
            mute_left_next     = cfg.mute_ticks;
            flags_next.armed   = 1'b1;
        end

        result.engaged = flags_next.engaged;
        result.mute    = (mute_left_next != '0);
    end

endmodule

// ----- rtl/core/thbs_checker.sv -----
module thbs_checker
    import thbs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    // Every accepted tick yields a result in the next cycle.
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted tick produced no result");

    // A result that leaves with no new tick behind it empties the output.
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !(in_valid && in_ready)) |=> !out_valid)
        else $error("result repeated without a new tick");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("output beat changed while stalled");

endmodule

bind tap_hold_bypass_switch thbs_checker u_thbs_checker (.*);

// ----- tb/sv/tb_tap_hold_bypass_switch.sv -----
`timescale 1ns / 100ps

module tb_tap_hold_bypass_switch;
    import thbs_pkg::*;

    // Edge ages are kept at the default width. A saturated age is far out
    // of reach of a run this short, so only the never-recorded edge and the
    // strict comparison are exercised at the largest thresholds.
    localparam int AGE_W = 16;
    localparam logic [AGE_W-1:0] AGE_SATURATED = '1;

    // The slowest correct run is well under a thousand beats, each delayed by
    // the worst gaps on both sides, plus the drains and the long hold-off.
    // This limit is set well above that.
    localparam int CYCLE_LIMIT = 200000;

    // The receiver holds off this long once, which fills the block.
    localparam int HOLDOFF_CYCLES = 40;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_beat_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_beat_t  out_data;
    logic       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    tap_hold_bypass_switch #(
        .AGE_WIDTH (AGE_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted engaged/mute levels, oldest first. One entry per accepted tick.
    out_beat_t predicted_outputs[$];

    int  cycle_count     = 0;
    int  ticks_sent      = 0;
    int  outputs_checked = 0;
    int  mismatch_count  = 0;
    int  settings_used   = 1;
    // When set, neither side inserts idle cycles.
    bit  steady_flow     = 1'b0;
    // Asks the receiver for one long hold-off on its next beat.
    bit  holdoff_request = 1'b0;

    // Predictor copy of the thresholds, starting from the reset values.
    logic [TICKS_WIDTH-1:0] debounce_cfg = DEBOUNCE_RESET;
    logic [TICKS_WIDTH-1:0] hold_cfg     = HOLD_RESET;
    logic [TICKS_WIDTH-1:0] rearm_cfg    = REARM_RESET;
    logic [MUTE_WIDTH-1:0]  mute_cfg     = MUTE_RESET;

    // Predictor copy of the switch state. The footswitch starts released.
    logic                   engaged_q   = 1'b0;
    logic                   armed_q     = 1'b0;
    logic                   last_sw_q   = 1'b1;
    logic                   fall_rec_q  = 1'b0;
    logic                   rise_rec_q  = 1'b0;
    logic [AGE_W-1:0]       fall_age_q  = '0;
    logic [AGE_W-1:0]       rise_age_q  = '0;
    logic [MUTE_WIDTH-1:0]  mute_left_q = '0;

    // One row of the directed table: either a register write or a tick.
    // Rows with typed_out set carry an expectation written by hand; all
    // others take the predictor's answer.
    typedef struct {
        bit                         is_write;
        logic [CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [CFG_DATA_WIDTH-1:0]  reg_value;
        in_beat_t                   tick;
        bit                         typed_out;
        out_beat_t                  want;
    } table_row_t;

    table_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_outputs.size());
            $display("tb_tap_hold_bypass_switch failed");
            $finish;
        end
    end

    function automatic in_beat_t pins(logic sw, logic det, logic rem);
        in_beat_t b;
        b.switch_level = sw;
        b.detect_level = det;
        b.remote_level = rem;
        return b;
    endfunction

    // An edge that was never recorded, or whose age has saturated, is older
    // than any threshold. Otherwise the comparison is strict.
    function automatic bit edge_stale(logic rec, logic [AGE_W-1:0] age,
                                      logic [TICKS_WIDTH-1:0] limit);
        return !rec || (age == AGE_SATURATED) || (age > limit);
    endfunction

    function automatic void switch_relay(logic on);
        engaged_q   = on;
        mute_left_q = mute_cfg;
    endfunction

    function automatic void forget_edges();
        fall_rec_q = 1'b0;
        fall_age_q = '0;
        rise_rec_q = 1'b0;
        rise_age_q = '0;
    endfunction

    // Advances the predicted state by one millisecond tick and returns the
    // engaged and mute levels that the block should report for it.
    function automatic out_beat_t bypass_tick(in_beat_t b);
        out_beat_t r;
        logic      sw;
        bit        release_settled;
        sw = b.switch_level;

        // Recorded ages move first and stick at their largest value.
        if (fall_rec_q && fall_age_q != AGE_SATURATED)
            fall_age_q = fall_age_q + 1'b1;
        if (rise_rec_q && rise_age_q != AGE_SATURATED)
            rise_age_q = rise_age_q + 1'b1;

        // Only the first falling edge is kept, and a rising edge is kept
        // only while armed.
        if (last_sw_q && !sw && !fall_rec_q)
        begin
            fall_rec_q = 1'b1;
            fall_age_q = '0;
        end
        if (!last_sw_q && sw && armed_q && !rise_rec_q)
        begin
            rise_rec_q = 1'b1;
            rise_age_q = '0;
        end
        last_sw_q = sw;

        if (mute_left_q != 0)
        begin
            // A running mute pulse pauses every decision.
            mute_left_q = mute_left_q - 1'b1;
        end
        else if (!b.detect_level)
        begin
            // Remote mode: engaged follows the inverted remote pin and the
            // armed flag and edge records are left alone.
            if (engaged_q == b.remote_level)
                switch_relay(!b.remote_level);
        end
        else if (armed_q)
        begin
            if (sw)
            begin
                release_settled = edge_stale(rise_rec_q, rise_age_q, debounce_cfg);
                if (engaged_q && release_settled &&
                    edge_stale(fall_rec_q, fall_age_q, hold_cfg))
                begin
                    // Long press: momentary use, drop back to bypass.
                    switch_relay(1'b0);
                    forget_edges();
                    armed_q = 1'b0;
                end
                else if (release_settled &&
                         edge_stale(fall_rec_q, fall_age_q, rearm_cfg))
                begin
                    // Short press: the toggle stands, only disarm.
                    forget_edges();
                    armed_q = 1'b0;
                end
            end
        end
        else if (!sw && edge_stale(fall_rec_q, fall_age_q, debounce_cfg))
        begin
            switch_relay(!engaged_q);
            armed_q = 1'b1;
        end

        r.engaged = engaged_q;
        r.mute    = (mute_left_q != 0);
        return r;
    endfunction

    // Offers one tick and returns at the falling edge after it was taken.
    // Valid stays high on return; the next call either keeps it high or
    // lowers it for a gap, so there is only one assignment per step.
    task automatic send_tick(input in_beat_t b, input bit typed_out,
                             input out_beat_t want);
        int        gap;
        out_beat_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        // The predictor always runs so that its state keeps pace, even when
        // the row carries a hand-written expectation.
        predicted = bypass_tick(b);
        predicted_outputs.push_back(typed_out ? want : predicted);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Stops offering beats and waits until every predicted result has been
    // seen. The block makes exactly one result per tick, so once the queue
    // is empty nothing is left in flight.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // Called at a falling edge while the block is idle.
    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_DEBOUNCE: debounce_cfg = value;
            REG_HOLD:     hold_cfg     = value;
            REG_REARM:    rearm_cfg    = value;
            REG_MUTE:     mute_cfg     = value[MUTE_WIDTH-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input int debounce, input int hold,
                                  input int rearm, input int mute);
        drain_results();
        write_register(REG_DEBOUNCE, CFG_DATA_WIDTH'(debounce));
        write_register(REG_HOLD,     CFG_DATA_WIDTH'(hold));
        write_register(REG_REARM,    CFG_DATA_WIDTH'(rearm));
        write_register(REG_MUTE,     CFG_DATA_WIDTH'(mute));
        settings_used++;
    endtask

    // Press or release length, aimed just past one of the current
    // thresholds so that every rule gets its turn. Huge thresholds are not
    // chased here.
    function automatic int press_length();
        int base;
        case ($urandom_range(0, 4))
            0:       base = 0;
            1:       base = int'(debounce_cfg);
            2:       base = int'(rearm_cfg);
            3:       base = int'(hold_cfg);
            default: base = int'(mute_cfg) + int'(debounce_cfg);
        endcase
        if (base > 60)
            base = $urandom_range(0, 60);
        return base + $urandom_range(1, 3);
    endfunction

    // Mostly clean press-and-release gestures in local mode, with some
    // contact bounce and some stretches of remote control in between.
    task automatic run_random_phase(input int n_ticks);
        int target;
        int kind;
        int len;
        int runs;
        logic rem;
        target = ticks_sent + n_ticks;
        while (ticks_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                len = press_length();
                repeat (len) send_tick(pins(1'b0, 1'b1, 1'($urandom)), 1'b0, '0);
                len = press_length();
                repeat (len) send_tick(pins(1'b1, 1'b1, 1'($urandom)), 1'b0, '0);
            end
            else if (kind < 85)
            begin
                len = $urandom_range(2, 6);
                repeat (len) send_tick(pins(1'($urandom), 1'b1, 1'($urandom)), 1'b0, '0);
            end
            else
            begin
                runs = $urandom_range(1, 3);
                repeat (runs)
                begin
                    rem = 1'($urandom);
                    len = $urandom_range(1, int'(mute_cfg) + 6);
                    repeat (len) send_tick(pins(1'($urandom), 1'b0, rem), 1'b0, '0);
                end
            end
        end
    endtask

    function automatic void add_tick(logic sw, logic det, logic rem);
        table_row_t row;
        row = '{1'b0, '0, '0, pins(sw, det, rem), 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed_tick(logic sw, logic det, logic rem,
                                           logic engaged, logic mute);
        table_row_t row;
        out_beat_t  want;
        want.engaged = engaged;
        want.mute    = mute;
        row = '{1'b0, '0, '0, pins(sw, det, rem), 1'b1, want};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(logic [CFG_INDEX_WIDTH-1:0] idx,
                                      logic [CFG_DATA_WIDTH-1:0] value);
        table_row_t row;
        row = '{1'b1, idx, value, '0, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    // Receiver: draws a stall before every beat, honors one long hold-off
    // when asked, and compares each result with the oldest prediction.
    initial
    begin
        int        stall;
        out_beat_t want;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (holdoff_request)
            begin
                stall = HOLDOFF_CYCLES;
                holdoff_request = 1'b0;
            end
            else
            begin
                stall = steady_flow ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            outputs_checked++;
            if (predicted_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result beat engaged=%b mute=%b with nothing expected",
                             $realtime, out_data.engaged, out_data.mute);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (out_data.engaged !== want.engaged || out_data.mute !== want.mute)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: result beat %0d: engaged %b (expected %b), ",
                                  "mute %b (expected %b)"},
                                 $realtime, outputs_checked, out_data.engaged,
                                 want.engaged, out_data.mute, want.mute);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        // Directed table. Rows with a typed result are the obvious ones:
        // the first tick after reset and the remote-mode changes without a
        // mute pulse. All gesture rows are checked against the predictor.
        add_typed_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);   // idle after reset
        add_write(REG_MUTE, '0);
        add_write(REG_DEBOUNCE, '0);
        add_write(REG_HOLD, 16'd3);
        add_write(REG_REARM, 16'd1);
        add_typed_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);   // remote engage, no mute
        add_typed_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);   // remote release
        // Zero debounce: the press needs one tick of age, then toggles on.
        add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b0);
        // Release after a press older than the hold time: momentary, so off.
        add_tick(1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b1, 1'b1);
        // Tap: the release comes before the hold time, so only disarm.
        add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b1, 1'b0);
        // Tap while engaged toggles off; the release then can only disarm.
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 1'b1);
        // Remote mode overrides while armed and leaves the arming alone.
        add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 1'b1);
        add_tick(1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b1, 1'b0);
        // Short mute pulse: the remote request waits until it has run out.
        add_write(REG_MUTE, 16'd2);
        add_tick(1'b1, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b0, 1'b1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                drain_results();
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            end
            else
            begin
                send_tick(directed_rows[i].tick, directed_rows[i].typed_out,
                          directed_rows[i].want);
            end
        end
        settings_used++;

        // Every threshold and the mute length at their maximum. A recorded
        // press or release never gets old enough to act, so the relay must
        // hold still through a long press and a long release.
        apply_settings(65535, 65535, 65535, 255);
        repeat (3) send_tick(pins(1'b1, 1'b1, 1'b1), 1'b0, '0);
        repeat (30) send_tick(pins(1'b0, 1'b1, 1'b0), 1'b0, '0);
        repeat (30) send_tick(pins(1'b1, 1'b1, 1'b1), 1'b0, '0);

        // All thresholds and the mute length at zero.
        apply_settings(0, 0, 0, 0);
        run_random_phase(100);

        // Moderate settings. Midway the sender waits for every result, then
        // the receiver holds off for a long stretch while beats keep coming,
        // so the block fills and stalls its input.
        apply_settings(2, 30, 10, 3);
        run_random_phase(60);
        drain_results();
        steady_flow = 1'b1;
        holdoff_request = 1'b1;
        run_random_phase(40);
        steady_flow = 1'b0;
        run_random_phase(40);

        repeat (3)
        begin
            apply_settings($urandom_range(0, 6), $urandom_range(0, 50),
                           $urandom_range(0, 30), $urandom_range(0, 8));
            run_random_phase(60);
        end

        // Back to the power-up defaults.
        apply_settings(int'(DEBOUNCE_RESET), int'(HOLD_RESET),
                       int'(REARM_RESET), int'(MUTE_RESET));
        run_random_phase(60);

        // Let everything arrive, then watch a little longer for stray beats.
        drain_results();
        repeat (20) @(negedge clk);

        $display("Sent %0d ticks under %0d threshold settings (zero, maximum, random, defaults),",
                 ticks_sent, settings_used);
        $display("compared %0d result beats, %0d mismatches.", outputs_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_tap_hold_bypass_switch passed");
        else
            $display("tb_tap_hold_bypass_switch failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/thbs_pkg.sv
rtl/core/thbs_cfg.sv
rtl/core/thbs_step.sv
rtl/core/tap_hold_bypass_switch.sv
rtl/core/thbs_checker.sv
tb/sv/tb_tap_hold_bypass_switch.sv
